// ===== design/frs_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the framed root stack.
package frs_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;
    localparam int IN_FW       = OP_W + ADDR_W + PTR_W;
    localparam int IN_TW       = ((IN_FW + 7) / 8) * 8;
    localparam int OUT_FW      = ST_W + ADDR_W + PTR_W + PTR_W;
    localparam int OUT_TW      = ((OUT_FW + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_FRAME = 3'd1;
    localparam logic [OP_W-1:0] OP_POP   = 3'd2;
    localparam logic [OP_W-1:0] OP_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_DEPTH = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_BEYOND = 2'd2;
    localparam logic [ST_W-1:0] ST_ZERO   = 2'd3;

    typedef enum logic [1:0] {
        RS_IDX,
        RS_IDX1,
        RS_TOPM1,
        RS_SCANM1
    } t_rsel;

    typedef struct packed {
        logic            load;
        logic            push;
        logic            rd_en;
        t_rsel           rd_sel;
        logic            scan_load;
        logic            scan_dec;
        logic            top_cut;
        logic            top_clear;
        logic            emit;
        logic [ST_W-1:0] emit_status;
        logic            emit_data;
        logic            used_plus1;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            addr_zero;
        logic            full;
        logic            empty;
        logic            idx_beyond;
        logic            idx1_beyond;
        logic            rdata_zero;
        logic            scan_zero;
        logic            out_free;
    } t_stat;

endpackage

// ===== design/frs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module frs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/frs_ctrl.sv =====
// Sequencing state machine for the framed root stack.
module frs_ctrl
    import frs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD1,
        S_RD2,
        S_POP
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.op)
                    OP_PUSH, OP_FRAME: begin
                        if (i_stat.out_free) begin
                            cmd.emit = 1'b1;
                            n_state  = S_IDLE;
                            if (i_stat.op == OP_PUSH && i_stat.addr_zero) begin
                                cmd.emit_status = ST_ZERO;
                            end else if (i_stat.full) begin
                                cmd.emit_status = ST_FULL;
                            end else begin
                                cmd.push = 1'b1;
                            end
                        end
                    end
                    OP_POP: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                cmd.emit = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end else begin
                            cmd.rd_en     = 1'b1;
                            cmd.rd_sel    = RS_TOPM1;
                            cmd.scan_load = 1'b1;
                            n_state       = S_POP;
                        end
                    end
                    OP_READ: begin
                        if (i_stat.idx_beyond) begin
                            if (i_stat.out_free) begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_BEYOND;
                                n_state         = S_IDLE;
                            end
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RS_IDX;
                            n_state    = S_RD1;
                        end
                    end
                    default: begin
                        if (i_stat.out_free) begin
                            cmd.emit = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                endcase
            end
            S_RD1: begin
                if (!i_stat.rdata_zero) begin
                    if (i_stat.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_data = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else if (i_stat.idx1_beyond) begin
                    if (i_stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_BEYOND;
                        n_state         = S_IDLE;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_IDX1;
                    n_state    = S_RD2;
                end
            end
            S_RD2: begin
                if (i_stat.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_data  = 1'b1;
                    cmd.used_plus1 = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_POP: begin
                if (i_stat.rdata_zero) begin
                    if (i_stat.out_free) begin
                        cmd.top_cut = 1'b1;
                        cmd.emit    = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (i_stat.scan_zero) begin
                    if (i_stat.out_free) begin
                        cmd.top_clear = 1'b1;
                        cmd.emit      = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RS_SCANM1;
                    cmd.scan_dec = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_cmd       = cmd;

endmodule

// ===== design/frs_dp.sv =====
// Datapath: request capture, top pointer, scan counter, entry RAM and result register.
module frs_dp
    import frs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IN_TW-1:0]  i_req_data,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    output logic [OUT_TW-1:0] o_res_data,
    input  t_cmd              i_cmd,
    output t_stat             o_stat
);

    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [PTR_W-1:0]  r_idx;
    logic [PTR_W-1:0]  r_top, n_top;
    logic [IDX_W-1:0]  r_scan;
    logic              r_res_valid;
    logic [OUT_TW-1:0] r_res_data;

    logic [PTR_W-1:0]  idx1;
    logic [PTR_W-1:0]  top_m1;
    logic [IDX_W-1:0]  raddr;
    logic [ADDR_W-1:0] rdata;
    logic [ADDR_W-1:0] wdata;
    logic [ADDR_W-1:0] res_addr;
    logic [PTR_W-1:0]  res_used;

    assign idx1   = r_idx + PTR_W'(1);
    assign top_m1 = r_top - PTR_W'(1);
    assign wdata  = (r_op == OP_PUSH) ? r_addr : '0;

    always_comb begin
        case (i_cmd.rd_sel)
            RS_IDX:    raddr = r_idx[IDX_W-1:0];
            RS_IDX1:   raddr = idx1[IDX_W-1:0];
            RS_TOPM1:  raddr = top_m1[IDX_W-1:0];
            RS_SCANM1: raddr = r_scan - IDX_W'(1);
            default:   raddr = '0;
        endcase
    end

    frs_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_top[IDX_W-1:0]),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_top = r_top;
        if (i_cmd.push) begin
            n_top = r_top + PTR_W'(1);
        end else if (i_cmd.top_cut) begin
            n_top = PTR_W'(r_scan);
        end else if (i_cmd.top_clear) begin
            n_top = '0;
        end
    end

    assign res_addr = i_cmd.emit_data ? rdata : '0;
    assign res_used = !i_cmd.emit_data ? '0 : (i_cmd.used_plus1 ? idx1 : r_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req_data[OP_W-1:0];
            r_addr <= i_req_data[OP_W +: ADDR_W];
            r_idx  <= i_req_data[OP_W+ADDR_W +: PTR_W];
        end
        if (i_cmd.scan_load) begin
            r_scan <= top_m1[IDX_W-1:0];
        end else if (i_cmd.scan_dec) begin
            r_scan <= r_scan - IDX_W'(1);
        end
        if (i_cmd.emit) begin
            r_res_data <= OUT_TW'({n_top, res_used, res_addr, i_cmd.emit_status});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_top <= n_top;
            if (i_cmd.emit) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_stat.op          = r_op;
    assign o_stat.addr_zero   = (r_addr == '0);
    assign o_stat.full        = (r_top == PTR_W'(STACK_DEPTH));
    assign o_stat.empty       = (r_top == '0);
    assign o_stat.idx_beyond  = (r_idx >= r_top);
    assign o_stat.idx1_beyond = ({1'b0, r_idx} + (PTR_W+1)'(1) >= {1'b0, r_top});
    assign o_stat.rdata_zero  = (rdata == '0);
    assign o_stat.scan_zero   = (r_scan == '0);
    assign o_stat.out_free    = !r_res_valid || i_res_ready;

    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res_data;

endmodule

// ===== design/framed_root_stack_unit.sv =====
// Top level of the framed root stack: controller, datapath and checks.
//
// Stack of root-slot addresses split into frames by zero marker entries.
// Slave stream carries one request per transfer: push slot, begin frame,
// pop frame, read slot or query depth. Master stream returns exactly one
// result per request, in order, with status, read address, used index and
// the depth after the request.
// Steps: push, begin frame, query depth and a read rejected on its index are
// accepted and then answered from the execute state; a read adds one RAM read,
// and a second one when it steps over a marker. A frame pop examines entries
// from the top down to and including the nearest marker, or down to the bottom,
// and the single RAM read port visits one entry per cycle. The result register
// and request readiness are both updated as the last step ends, so a new
// request can be taken in the same cycle as the result appears.
// Reset clears the top pointer and the result valid flag; entry RAM is not
// cleared, as only entries below the top are ever read.
// When the receiver stalls, the pending result is held and the next request
// is still taken and worked on until it needs the output register.
module framed_root_stack_unit
    import frs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // [2:0] operation, [34:3] slot_address, [45:35] slot_index
    input  logic [IN_TW-1:0]  i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // [1:0] status, [33:2] read_address, [44:34] used_index, [55:45] depth
    output logic [OUT_TW-1:0] o_m_tdata
);

    t_cmd  cmd;
    t_stat stat;

    frs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    frs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (i_s_tdata),
        .i_res_ready (i_m_tready),
        .o_res_valid (o_m_tvalid),
        .o_res_data  (o_m_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[ST_W+ADDR_W+PTR_W +: PTR_W] <= PTR_W'(STACK_DEPTH)))
        else $error("result depth beyond stack size");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[ST_W-1:0] != ST_OK) |->
            (o_m_tdata[ST_W +: ADDR_W] == '0 && o_m_tdata[ST_W+ADDR_W +: PTR_W] == '0))
        else $error("failed request returned read data");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while previous one in progress");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result written over pending result");
`endif

endmodule
